// ===== rtl/irgt_pkg.sv =====
// Package for the IP range group table: sizes, opcodes, status codes,
// transaction structs and the 128-bit compare helper. No dependencies.
package irgt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int GROUP_COUNT   = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  group_id;
        logic        is_ipv6;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [63:0] range_max_hi;
        logic [63:0] range_max_lo;
    } in_t;

    typedef struct packed {
        logic       matched;
        logic [1:0] status;
    } out_t;

    // one table entry, also the normalized operand of a transaction
    typedef struct packed {
        logic        v6;
        logic [3:0]  grp;
        logic [63:0] mnh;
        logic [63:0] mnl;
        logic [63:0] mxh;
        logic [63:0] mxl;
    } ent_t;

    typedef struct packed {
        logic [1:0] op;
        ent_t       ent;
    } oper_t;

    // flags carried along the cell chain
    typedef struct packed {
        logic             hit;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
    } tok_t;

    // insert commit, broadcast to all cells
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } wr_t;

    function automatic logic le128(input logic [63:0] ahi, input logic [63:0] alo,
                                   input logic [63:0] bhi, input logic [63:0] blo);
        return (ahi < bhi) || ((ahi == bhi) && (alo <= blo));
    endfunction

endpackage

// ===== rtl/irgt_cell.sv =====
// One table cell: holds one range entry and its valid bit, checks the
// passing transaction against it and hands the flags on. Uses irgt_pkg.
module irgt_cell
    import irgt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] cell_idx,
    input  oper_t            oper,
    input  logic             act_in,
    input  tok_t             tok_in,
    input  wr_t              wr,
    output logic             act_out,
    output tok_t             tok_out
);

    logic valid_reg, valid_next;
    ent_t ent_reg;
    logic act_reg;
    tok_t tok_reg, tok_next;
    logic key_eq, same, inrange, hit_here, wr_here;

    assign wr_here = wr.en && (wr.idx == cell_idx);
    assign key_eq  = valid_reg && (ent_reg.grp == oper.ent.grp) && (ent_reg.v6 == oper.ent.v6);
    assign same    = valid_reg && (ent_reg == oper.ent);
    assign inrange = key_eq
                     && le128(ent_reg.mnh, ent_reg.mnl, oper.ent.mnh, oper.ent.mnl)
                     && le128(oper.ent.mnh, oper.ent.mnl, ent_reg.mxh, ent_reg.mxl);
    assign hit_here = (oper.op == OP_LOOKUP) ? inrange : same;

    always_comb begin
        tok_next     = tok_in;
        tok_next.hit = tok_in.hit | hit_here;
        if (!tok_in.free_found && !valid_reg) begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = cell_idx;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (act_in && (oper.op == OP_DELETE) && same && !tok_in.hit) begin
            valid_next = 1'b0;
        end
        if (wr_here) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            act_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            act_reg   <= act_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_here) begin
            ent_reg <= oper.ent;
        end
        tok_reg <= tok_next;
    end

    assign act_out = act_reg;
    assign tok_out = tok_reg;

endmodule

// ===== rtl/ip_range_group_table.sv =====
// IP range group table: a row of TABLE_ENTRIES cells that a transaction
// walks one cell per cycle. One transaction is in flight at a time, so a new
// one is taken only after the last has walked the whole cell row and its
// result has been registered for the output.
// A result waiting on m_ready does not block the next input. Synchronous
// active-low reset clears the table and all control state.
module ip_range_group_table
    import irgt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       go_reg;
    oper_t      oper_reg;
    tok_t       end_tok_reg;
    logic       m_valid_reg;
    out_t       out_reg, out_next;
    logic       s_acc, out_free, finish, grp_ok;
    wr_t        wr;
    oper_t      oper_in;

    logic act_chain [0:TABLE_ENTRIES];
    tok_t tok_chain [0:TABLE_ENTRIES];

    assign s_ready  = (state_reg == S_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == S_FIN) && out_free;
    assign grp_ok   = 32'(oper_reg.ent.grp) < GROUP_COUNT;

    always_comb begin
        oper_in.op      = s_data.opcode;
        oper_in.ent.v6  = s_data.is_ipv6;
        oper_in.ent.grp = s_data.group_id;
        if (s_data.is_ipv6) begin
            oper_in.ent.mnh = s_data.addr_hi;
            oper_in.ent.mnl = s_data.addr_lo;
            oper_in.ent.mxh = s_data.range_max_hi;
            oper_in.ent.mxl = s_data.range_max_lo;
        end else begin
            oper_in.ent.mnh = '0;
            oper_in.ent.mnl = {32'd0, s_data.addr_lo[31:0]};
            oper_in.ent.mxh = '0;
            oper_in.ent.mxl = {32'd0, s_data.range_max_lo[31:0]};
        end
    end

    assign act_chain[0] = go_reg;
    assign tok_chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
            irgt_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (IDX_W'(gi)),
                .oper     (oper_reg),
                .act_in   (act_chain[gi]),
                .tok_in   (tok_chain[gi]),
                .wr       (wr),
                .act_out  (act_chain[gi+1]),
                .tok_out  (tok_chain[gi+1])
            );
        end
    endgenerate

    always_comb begin
        wr.en  = finish && (oper_reg.op == OP_INSERT) && grp_ok
                 && !end_tok_reg.hit && end_tok_reg.free_found;
        wr.idx = end_tok_reg.free_idx;
    end

    always_comb begin
        out_next = '0;
        case (oper_reg.op)
            OP_LOOKUP: begin
                out_next.matched = grp_ok && end_tok_reg.hit;
            end
            OP_INSERT: begin
                if (!grp_ok) begin
                    out_next.status = STAT_FULL;
                end else if (!end_tok_reg.hit && !end_tok_reg.free_found) begin
                    out_next.status = STAT_FULL;
                end
            end
            OP_DELETE: begin
                if (!end_tok_reg.hit) begin
                    out_next.status = STAT_NOT_FOUND;
                end
            end
            default: begin
                out_next = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                if (act_chain[TABLE_ENTRIES]) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            go_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            go_reg    <= s_acc;
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            oper_reg <= oper_in;
        end
        if ((state_reg == S_RUN) && act_chain[TABLE_ENTRIES]) begin
            end_tok_reg <= tok_chain[TABLE_ENTRIES];
        end
        if (finish) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/irgt_checker.sv =====
// Port-level checks for ip_range_group_table, attached by bind.
// Uses irgt_pkg.
module irgt_checker
    import irgt_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a transaction is in flight");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == STAT_OK) || (m_data.status == STAT_FULL)
                    || (m_data.status == STAT_NOT_FOUND))
        else $error("bad status code");

    a_match_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.matched |-> m_data.status == STAT_OK)
        else $error("match reported with error status");

endmodule

bind ip_range_group_table irgt_checker u_irgt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
